### rtl/core/bba_pkg.sv
// ============================================================================
// bba_pkg: shared definitions of the buddy block allocator
// Sizes, result codes, microcode formats and the control program itself.
// ============================================================================
package bba_pkg;

   // Area and tree geometry.
   localparam int TOTAL_LOG2   = 16;
   localparam int MIN_LOG2     = 4;
   localparam int LEVELS_BELOW = TOTAL_LOG2 - MIN_LOG2;
   localparam int NODE_W       = LEVELS_BELOW + 1;
   localparam int NODE_COUNT   = 2 << LEVELS_BELOW;

   // Field widths.
   localparam int LG_W     = 5;
   localparam int SIZE_W   = 17;
   localparam int OFFSET_W = 16;
   localparam int STEP_W   = 4;

   localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
   localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(1) << LEVELS_BELOW;
   localparam logic [NODE_W-1:0] LAST_NODE = {NODE_W{1'b1}};
   localparam logic [SIZE_W-1:0] AREA_SIZE = SIZE_W'(1) << TOTAL_LOG2;
   localparam logic [LG_W-1:0]   TOP_LG    = LG_W'(TOTAL_LOG2);
   localparam logic [LG_W-1:0]   MIN_LG    = LG_W'(MIN_LOG2);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_BAD_SIZE  = 2'd1,
      ERR_NO_SPACE  = 2'd2,
      ERR_NOT_ALLOC = 2'd3
   } err_type;

   // Datapath operations, one per control word.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LATCH,
      OP_READ_ROOT,
      OP_READ_LEFT,
      OP_DESCEND,
      OP_MARK,
      OP_MERGE,
      OP_READ_LEAF,
      OP_WALK,
      OP_REPLY_OK,
      OP_REPLY_ALLOC_ERR,
      OP_REPLY_FREE_ERR
   } op_type;

   // Jump conditions, one per control word.
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_CLEAR_MORE,
      C_NO_START,
      C_FREE,
      C_ALLOC_FAIL,
      C_ABOVE_SIZE,
      C_AT_ROOT,
      C_MERGE_MORE,
      C_OFF_OUT,
      C_WALK_MORE,
      C_FREE_OK
   } cond_type;

   // Program addresses.
   localparam logic [STEP_W-1:0] ST_CLEAR     = 4'd0;
   localparam logic [STEP_W-1:0] ST_IDLE      = 4'd1;
   localparam logic [STEP_W-1:0] ST_DISPATCH  = 4'd2;
   localparam logic [STEP_W-1:0] ST_ROOT_CHK  = 4'd3;
   localparam logic [STEP_W-1:0] ST_DESCEND   = 4'd4;
   localparam logic [STEP_W-1:0] ST_MARK      = 4'd5;
   localparam logic [STEP_W-1:0] ST_MERGE     = 4'd6;
   localparam logic [STEP_W-1:0] ST_DONE      = 4'd7;
   localparam logic [STEP_W-1:0] ST_ERR_ALLOC = 4'd8;
   localparam logic [STEP_W-1:0] ST_FREE_LEAF = 4'd9;
   localparam logic [STEP_W-1:0] ST_FREE_WALK = 4'd10;
   localparam logic [STEP_W-1:0] ST_FREE_CHK  = 4'd11;
   localparam logic [STEP_W-1:0] ST_ERR_FREE  = 4'd12;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } uword_type;

   // Status from the datapath that the jump conditions test.
   typedef struct packed {
      logic start;
      logic cmd_free;
      logic alloc_fail;
      logic above_size;
      logic at_root;
      logic merge_more;
      logic off_out;
      logic walk_more;
      logic free_ok;
      logic clear_more;
   } flags_type;

   // The control program. A taken condition jumps to target, otherwise the
   // step counter moves on to the next word.
   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] addr);
      uword_type w;
      w.op     = OP_NONE;
      w.cond   = C_ALWAYS;
      w.target = ST_IDLE;
      unique case (addr)
         ST_CLEAR:     begin w.op = OP_CLEAR;           w.cond = C_CLEAR_MORE;
                             w.target = ST_CLEAR;     end
         ST_IDLE:      begin w.op = OP_LATCH;           w.cond = C_NO_START;
                             w.target = ST_IDLE;      end
         ST_DISPATCH:  begin w.op = OP_READ_ROOT;       w.cond = C_FREE;
                             w.target = ST_FREE_LEAF; end
         ST_ROOT_CHK:  begin w.op = OP_READ_LEFT;       w.cond = C_ALLOC_FAIL;
                             w.target = ST_ERR_ALLOC; end
         ST_DESCEND:   begin w.op = OP_DESCEND;         w.cond = C_ABOVE_SIZE;
                             w.target = ST_DESCEND;   end
         ST_MARK:      begin w.op = OP_MARK;            w.cond = C_AT_ROOT;
                             w.target = ST_DONE;      end
         ST_MERGE:     begin w.op = OP_MERGE;           w.cond = C_MERGE_MORE;
                             w.target = ST_MERGE;     end
         ST_DONE:      begin w.op = OP_REPLY_OK;        w.cond = C_ALWAYS;
                             w.target = ST_IDLE;      end
         ST_ERR_ALLOC: begin w.op = OP_REPLY_ALLOC_ERR; w.cond = C_ALWAYS;
                             w.target = ST_IDLE;      end
         ST_FREE_LEAF: begin w.op = OP_READ_LEAF;       w.cond = C_OFF_OUT;
                             w.target = ST_ERR_FREE;  end
         ST_FREE_WALK: begin w.op = OP_WALK;            w.cond = C_WALK_MORE;
                             w.target = ST_FREE_WALK; end
         ST_FREE_CHK:  begin w.op = OP_NONE;            w.cond = C_FREE_OK;
                             w.target = ST_MARK;      end
         ST_ERR_FREE:  begin w.op = OP_REPLY_FREE_ERR;  w.cond = C_ALWAYS;
                             w.target = ST_IDLE;      end
         default:      begin w.op = OP_NONE;            w.cond = C_ALWAYS;
                             w.target = ST_IDLE;      end
      endcase
      return w;
   endfunction

   // Log2 of the smallest power of two that holds size, at least MIN_LOG2.
   function automatic logic [LG_W-1:0] size_to_log(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] m;
      logic [LG_W-1:0]   k;
      m = size - SIZE_W'(1);
      k = MIN_LG;
      for (int i = 0; i < SIZE_W; i++) begin
         if (m[i] && (i + 1 > MIN_LOG2)) begin
            k = LG_W'(i + 1);
         end
      end
      return k;
   endfunction

endpackage

### rtl/core/bba_ram.sv
// ============================================================================
// bba_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bba_sequencer.sv
// ============================================================================
// bba_sequencer: step counter and control store
// Fetches one control word per cycle and resolves conditional jumps.
// ============================================================================
module bba_sequencer
   import bba_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output uword_type uword,
   output logic      idle
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              taken;

   assign uword = ucode_rom(step_ff);
   assign idle  = (step_ff == ST_IDLE);

   always_comb begin
      unique case (uword.cond)
         C_NEVER:      taken = 1'b0;
         C_ALWAYS:     taken = 1'b1;
         C_CLEAR_MORE: taken = flags.clear_more;
         C_NO_START:   taken = !flags.start;
         C_FREE:       taken = flags.cmd_free;
         C_ALLOC_FAIL: taken = flags.alloc_fail;
         C_ABOVE_SIZE: taken = flags.above_size;
         C_AT_ROOT:    taken = flags.at_root;
         C_MERGE_MORE: taken = flags.merge_more;
         C_OFF_OUT:    taken = flags.off_out;
         C_WALK_MORE:  taken = flags.walk_more;
         C_FREE_OK:    taken = flags.free_ok;
         default:      taken = 1'b0;
      endcase
      step_in = taken ? uword.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/core/bba_datapath.sv
// ============================================================================
// bba_datapath: tree walker datapath of the buddy block allocator
// Node and level registers, merge logic, tree memory and response registers.
// ============================================================================
module bba_datapath
   import bba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  uword_type           uword,
   output flags_type           flags,
   input  logic                start,
   input  logic                req_command,
   input  logic [SIZE_W-1:0]   req_request_size,
   input  logic [OFFSET_W-1:0] req_free_offset,
   output logic                rsp_valid,
   output logic                rsp_ok,
   output logic [1:0]          rsp_error_code,
   output logic [OFFSET_W-1:0] rsp_block_offset,
   output logic [LG_W-1:0]     rsp_block_size_log
);

   // Request registers.
   logic                cmd_ff;
   logic                size_bad_ff;
   logic [LG_W-1:0]     k_ff;
   logic [OFFSET_W-1:0] off_ff;

   // Walk registers.
   logic [NODE_W-1:0]   node_ff;
   logic [LG_W-1:0]     lg_ff;
   logic [LG_W-1:0]     cur_ff;
   logic [OFFSET_W-1:0] res_off_ff;
   logic [LG_W-1:0]     res_lg_ff;

   // Initialization sweep.
   logic [NODE_W-1:0]   clr_node_ff;
   logic [LG_W-1:0]     clr_val_ff;

   // Response registers.
   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   err_type             rsp_err_ff;
   logic [OFFSET_W-1:0] rsp_off_ff;
   logic [LG_W-1:0]     rsp_lg_ff;

   // Memory ports.
   logic                wr_en;
   logic [NODE_W-1:0]   wr_addr;
   logic [LG_W-1:0]     wr_data;
   logic                rd_en;
   logic [NODE_W-1:0]   rd_addr;
   logic [LG_W-1:0]     rd_data;

   // Derived values.
   logic [NODE_W-1:0]   left_child;
   logic [NODE_W-1:0]   pick;
   logic [NODE_W-1:0]   parent;
   logic [NODE_W-1:0]   leaf;
   logic [LG_W-1:0]     child_full;
   logic [LG_W-1:0]     merged;
   logic [LG_W-1:0]     mark_val;
   logic [31:0]         span_base;
   logic [OFFSET_W-1:0] low_mask;

   bba_ram #(
      .WIDTH (LG_W),
      .DEPTH (NODE_COUNT)
   ) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      left_child = {node_ff[NODE_W-2:0], 1'b0};
      pick       = (rd_data > k_ff) ? left_child : (left_child | NODE_W'(1));
      parent     = node_ff >> 1;
      leaf       = LEAF_BASE + NODE_W'(off_ff >> MIN_LOG2);
      child_full = lg_ff + LG_W'(1);
      if (cur_ff == child_full && rd_data == child_full) begin
         merged = lg_ff + LG_W'(2);
      end else begin
         merged = (cur_ff > rd_data) ? cur_ff : rd_data;
      end
      mark_val  = (cmd_ff == CMD_FREE) ? child_full : '0;
      span_base = 32'(node_ff) << lg_ff;
      low_mask  = ~({OFFSET_W{1'b1}} << lg_ff);
   end

   // Memory access per operation.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = node_ff;
      wr_data = mark_val;
      rd_en   = 1'b0;
      rd_addr = node_ff;
      unique case (uword.op)
         OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_node_ff;
            wr_data = clr_val_ff;
         end
         OP_READ_ROOT: begin
            rd_en   = 1'b1;
            rd_addr = ROOT_NODE;
         end
         OP_READ_LEFT: begin
            rd_en   = 1'b1;
            rd_addr = left_child;
         end
         OP_DESCEND: begin
            rd_en   = (lg_ff != k_ff);
            rd_addr = {pick[NODE_W-2:0], 1'b0};
         end
         OP_MARK: begin
            wr_en   = 1'b1;
            rd_en   = 1'b1;
            rd_addr = node_ff ^ NODE_W'(1);
         end
         OP_MERGE: begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = merged;
            rd_en   = 1'b1;
            rd_addr = parent ^ NODE_W'(1);
         end
         OP_READ_LEAF: begin
            rd_en   = 1'b1;
            rd_addr = leaf;
         end
         OP_WALK: begin
            rd_en   = (rd_data != '0);
            rd_addr = parent;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      flags.start      = start;
      flags.cmd_free   = (cmd_ff == CMD_FREE);
      flags.alloc_fail = size_bad_ff || (rd_data <= k_ff);
      flags.above_size = (lg_ff != k_ff);
      flags.at_root    = (node_ff == ROOT_NODE);
      flags.merge_more = (parent != ROOT_NODE);
      flags.off_out    = ((32'(off_ff) >> TOTAL_LOG2) != 32'd0);
      flags.walk_more  = (rd_data != '0) && (node_ff != ROOT_NODE);
      flags.free_ok    = (node_ff != '0) && ((off_ff & low_mask) == '0);
      flags.clear_more = (clr_node_ff != LAST_NODE);
   end

   // Sweep counters: each tree level holds its own full size after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_node_ff <= ROOT_NODE;
         clr_val_ff  <= TOP_LG + LG_W'(1);
      end else if (uword.op == OP_CLEAR) begin
         clr_node_ff <= clr_node_ff + NODE_W'(1);
         if ((clr_node_ff & (clr_node_ff + NODE_W'(1))) == '0) begin
            clr_val_ff <= clr_val_ff - LG_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (uword.op)
         OP_LATCH: begin
            if (start) begin
               cmd_ff      <= req_command;
               size_bad_ff <= (req_request_size == '0) || (req_request_size > AREA_SIZE);
               k_ff        <= size_to_log(req_request_size);
               off_ff      <= req_free_offset;
            end
         end
         OP_READ_ROOT: begin
            node_ff <= ROOT_NODE;
            lg_ff   <= TOP_LG;
         end
         OP_DESCEND: begin
            if (lg_ff != k_ff) begin
               node_ff <= pick;
               lg_ff   <= lg_ff - LG_W'(1);
            end
         end
         OP_MARK: begin
            cur_ff     <= mark_val;
            res_off_ff <= OFFSET_W'(span_base[TOTAL_LOG2-1:0]);
            res_lg_ff  <= lg_ff;
         end
         OP_MERGE: begin
            cur_ff  <= merged;
            node_ff <= parent;
            lg_ff   <= lg_ff + LG_W'(1);
         end
         OP_READ_LEAF: begin
            node_ff <= leaf;
            lg_ff   <= MIN_LG;
         end
         OP_WALK: begin
            if (rd_data != '0) begin
               node_ff <= parent;
               lg_ff   <= lg_ff + LG_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (uword.op == OP_REPLY_OK) || (uword.op == OP_REPLY_ALLOC_ERR)
                         || (uword.op == OP_REPLY_FREE_ERR);
      end
   end

   always_ff @(posedge clock) begin
      unique case (uword.op)
         OP_REPLY_OK: begin
            rsp_ok_ff  <= 1'b1;
            rsp_err_ff <= ERR_NONE;
            rsp_off_ff <= res_off_ff;
            rsp_lg_ff  <= res_lg_ff;
         end
         OP_REPLY_ALLOC_ERR: begin
            rsp_ok_ff  <= 1'b0;
            rsp_err_ff <= size_bad_ff ? ERR_BAD_SIZE : ERR_NO_SPACE;
            rsp_off_ff <= '0;
            rsp_lg_ff  <= '0;
         end
         OP_REPLY_FREE_ERR: begin
            rsp_ok_ff  <= 1'b0;
            rsp_err_ff <= ERR_NOT_ALLOC;
            rsp_off_ff <= '0;
            rsp_lg_ff  <= '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_error_code     = rsp_err_ff;
   assign rsp_block_offset   = rsp_off_ff;
   assign rsp_block_size_log = rsp_lg_ff;

endmodule

### rtl/core/buddy_block_allocator_core.sv
// ============================================================================
// buddy_block_allocator_core: binary buddy allocator, top level
// Allocates and frees power-of-two blocks of a 64 KiB area, minimum 16 bytes.
// ============================================================================
//
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ------------------------------
// request   in         start high, busy low      req_command, req_request_size,
//                                                req_free_offset
// response  out        rsp_valid, one cycle      rsp_ok, rsp_error_code,
//                                                rsp_block_offset,
//                                                rsp_block_size_log
//
// A request is taken at a rising edge with start high and busy low; its
// response appears on rsp_valid for exactly one cycle and cannot be held off.
// An allocation walks down from the root to its block, a free walks up from
// the leaf under its offset, and both then climb back to the root in a merge
// pass; an error ends sooner. The pace is set by the tree memory: the walk
// down (or up, for a free) and the merge pass back to the root each visit one
// level per cycle through its single read port.
// After reset the block sweeps all 8191 tree nodes, one per cycle, and holds
// busy high until the sweep is done.
//
// The tree lives in an 8192-entry memory, one entry per node (node 1 is the
// root, the children of n are 2n and 2n+1). Each entry holds zero when its
// span is wholly used, or else log2 of the largest free block in it plus one.
// A short control program steps a plain datapath through the work: read the
// root, descend to the leftmost fitting node, mark it, then recompute each
// ancestor from the node and its buddy, merging two wholly free buddies.
// A free starts at the leaf under the offset and climbs to the first used
// node, which must start exactly at that offset.

module buddy_block_allocator_core
   import bba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [SIZE_W-1:0]   req_request_size,
   input  logic [OFFSET_W-1:0] req_free_offset,
   output logic                rsp_valid,
   output logic                rsp_ok,
   output logic [1:0]          rsp_error_code,
   output logic [OFFSET_W-1:0] rsp_block_offset,
   output logic [LG_W-1:0]     rsp_block_size_log
);

   uword_type uword;
   flags_type flags;
   logic      idle;

   // The control store and its step counter.
   bba_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uword (uword),
      .idle  (idle)
   );

   // Registers, merge logic and the tree memory driven by the control word.
   bba_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .uword              (uword),
      .flags              (flags),
      .start              (start),
      .req_command        (req_command),
      .req_request_size   (req_request_size),
      .req_free_offset    (req_free_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_error_code     (rsp_error_code),
      .rsp_block_offset   (rsp_block_offset),
      .rsp_block_size_log (rsp_block_size_log)
   );

   // Requests are taken only at the idle step of the program.
   assign busy = !idle;

   // A taken request always makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy afterwards");

   // The response strobe comes out with the sequencer back at its idle step.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while sequencer still busy");

   // A response strobe lasts one cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // Failed commands carry an error code and an empty block.
   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_error_code != ERR_NONE
         && rsp_block_offset == '0 && rsp_block_size_log == '0))
      else $error("error response with inconsistent payload");

endmodule

### test/buddy_block_allocator_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// buddy_block_allocator_core_test: self-checking regression of the allocator
// Drives allocate and free requests, predicts every response from a private
// model of the buddy tree, and compares each response field by field.
// ============================================================================

module buddy_block_allocator_core_test;
   import bba_pkg::*;

   // Run shape. The last CALM_TAIL requests are sent back to back.
   localparam int REQUEST_TOTAL  = 1750;
   localparam int CALM_TAIL      = 200;
   localparam int SETTLE_CYCLES  = 40;
   // The post-reset sweep of every tree node alone holds busy high.
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      logic                command;
      logic [SIZE_W-1:0]   size;
      logic [OFFSET_W-1:0] offset;
      logic                drain_first;   // hold off until nothing is in flight
   } request_type;

   typedef struct packed {
      logic                ok;
      err_type             code;
      logic [OFFSET_W-1:0] offset;
      logic [LG_W-1:0]     size_log;
   } reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_command = CMD_ALLOC;
   logic [SIZE_W-1:0]   req_request_size = '0;
   logic [OFFSET_W-1:0] req_free_offset = '0;
   logic                rsp_valid;
   logic                rsp_ok;
   logic [1:0]          rsp_error_code;
   logic [OFFSET_W-1:0] rsp_block_offset;
   logic [LG_W-1:0]     rsp_block_size_log;

   buddy_block_allocator_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_request_size   (req_request_size),
      .req_free_offset    (req_free_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_error_code     (rsp_error_code),
      .rsp_block_offset   (rsp_block_offset),
      .rsp_block_size_log (rsp_block_size_log)
   );

   always #1 clock = ~clock;

   // Private copy of the buddy tree: zero when a node's span is wholly used,
   // otherwise log2 of its largest free block plus one. Node 1 is the root.
   logic [LG_W-1:0] span_free [NODE_COUNT];

   request_type backlog[$];            // requests waiting for the driver
   reply_type   expected_replies[$];   // predictions waiting for their response
   int          held_blocks[$];        // offsets of granted blocks not yet freed

   request_type active_req;
   int       in_flight = 0;
   int       sent_count = 0;
   int       gap_left = 0;
   int       gap_mode = 0;
   int       quiet_cycles = 0;
   int       error_count = 0;
   int       reply_count = 0;
   int       code_count [4] = '{0, 0, 0, 0};

   task automatic flag_error(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Recompute every ancestor of a node whose block is 2^lg bytes. Two wholly
   // free buddies merge into a wholly free parent.
   function automatic void update_ancestors(input int unsigned node, input int unsigned lg);
      int unsigned parent;
      logic [LG_W-1:0] l;
      logic [LG_W-1:0] r;
      while (node > 1) begin
         parent = node >> 1;
         l = span_free[parent << 1];
         r = span_free[(parent << 1) | 1];
         if (l == lg + 1 && r == lg + 1) begin
            span_free[parent] = LG_W'(lg + 2);
         end else begin
            span_free[parent] = (l > r) ? l : r;
         end
         lg++;
         node = parent;
      end
   endfunction

   function automatic reply_type predict_grant(input logic [SIZE_W-1:0] size);
      reply_type res;
      int unsigned k;
      int unsigned lg;
      int unsigned depth;
      int unsigned node;
      int unsigned left;
      res = '{ok: 1'b0, code: ERR_NONE, offset: '0, size_log: '0};
      if (size == 0 || size > AREA_SIZE) begin
         res.code = ERR_BAD_SIZE;
         return res;
      end
      k = MIN_LOG2;
      while ((longint'(1) << k) < longint'(size)) k++;
      if (span_free[1] < k + 1) begin
         res.code = ERR_NO_SPACE;
         return res;
      end
      // Descend toward the leftmost node whose span still fits the request.
      node = 1;
      lg = TOTAL_LOG2;
      depth = 0;
      while (lg > k) begin
         left = node << 1;
         node = (span_free[left] >= k + 1) ? left : (left | 1);
         lg--;
         depth++;
      end
      span_free[node] = '0;
      update_ancestors(node, lg);
      res.ok = 1'b1;
      res.offset = OFFSET_W'((node - (1 << depth)) << lg);
      res.size_log = LG_W'(lg);
      return res;
   endfunction

   function automatic reply_type predict_release(input logic [OFFSET_W-1:0] off);
      reply_type res;
      int unsigned node;
      int unsigned lg;
      res = '{ok: 1'b0, code: ERR_NOT_ALLOC, offset: '0, size_log: '0};
      // Climb from the leaf under the offset to the first wholly used node.
      node = (1 << LEVELS_BELOW) + (int'(off) >> MIN_LOG2);
      lg = MIN_LOG2;
      while (node >= 1 && span_free[node] != 0) begin
         node = node >> 1;
         lg++;
      end
      if (node == 0 || (int'(off) & ((1 << lg) - 1)) != 0) begin
         return res;
      end
      span_free[node] = LG_W'(lg + 1);
      update_ancestors(node, lg);
      res.ok = 1'b1;
      res.code = ERR_NONE;
      res.offset = off;
      res.size_log = LG_W'(lg);
      return res;
   endfunction

   // Driver. A request is presented with start high and held until the block
   // takes it; the prediction is made at the edge that takes it, so the tree
   // copy moves in the same order as the hardware.
   always @(posedge clock) begin
      logic      taken;
      reply_type want;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            if (active_req.command == CMD_ALLOC) begin
               want = predict_grant(active_req.size);
               if (want.ok) held_blocks.push_back(int'(want.offset));
            end else begin
               want = predict_release(active_req.offset);
            end
            expected_replies.push_back(want);
            in_flight++;
            sent_count++;
            // Idle behavior changes every few dozen requests, including
            // stretches with no idling at all, and stops near the end.
            if (sent_count % 40 == 0) gap_mode = $urandom_range(0, 2);
            if (sent_count < REQUEST_TOTAL - CALM_TAIL && gap_mode != 0 &&
                $urandom_range(0, 3) < gap_mode) begin
               gap_left = $urandom_range(1, 19);
            end
         end
         if (rsp_valid) in_flight--;
         if (!start || taken) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (backlog.size() > 0 &&
                         !(backlog[0].drain_first && in_flight != 0)) begin
               active_req = backlog.pop_front();
               req_command <= active_req.command;
               req_request_size <= active_req.size;
               req_free_offset <= active_req.offset;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every strobe is matched against the oldest prediction.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid) begin
         reply_count++;
         code_count[rsp_error_code]++;
         if (expected_replies.size() == 0) begin
            flag_error($sformatf("response %0d arrived with no request outstanding",
                                 reply_count));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_ok !== want.ok)
               flag_error($sformatf("response %0d: ok %b, want %b",
                                    reply_count, rsp_ok, want.ok));
            if (rsp_error_code !== want.code)
               flag_error($sformatf("response %0d: error_code %0d, want %s",
                                    reply_count, rsp_error_code, want.code.name()));
            if (rsp_block_offset !== want.offset)
               flag_error($sformatf("response %0d: block_offset 0x%h, want 0x%h",
                                    reply_count, rsp_block_offset, want.offset));
            if (rsp_block_size_log !== want.size_log)
               flag_error($sformatf("response %0d: block_size_log %0d, want %0d",
                                    reply_count, rsp_block_size_log, want.size_log));
         end
      end
   end

   // Watchdog. Any edge that moves a request or a response restarts the count.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d requests sent", quiet_cycles,
                  sent_count);
         $display("buddy_block_allocator_core regression: fail");
         $finish;
      end
   end

   task automatic queue_request(input logic cmd, input int size, input int off,
                                input logic drain);
      request_type r;
      r.command = cmd;
      r.size = SIZE_W'(size);
      r.offset = OFFSET_W'(off);
      r.drain_first = drain;
      backlog.push_back(r);
   endtask

   // Random allocation size: mostly small blocks so that the tree fragments,
   // some exact powers of two, and a little noise outside the legal range.
   function automatic int pick_size();
      int lg;
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 0;
      if (pick == 1) return $urandom_range(AREA_SIZE + 1, (1 << SIZE_W) - 1);
      lg = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 9) : $urandom_range(10, 16);
      if (lg == 0) return 1;
      if (pick < 7) return 1 << lg;
      return $urandom_range((1 << (lg - 1)) + 1, 1 << lg);
   endfunction

   initial begin
      int made;
      int alloc_pct;
      int idx;
      int off;
      logic drain;

      for (int d = 0; d <= LEVELS_BELOW; d++) begin
         for (int n = 1 << d; n < (2 << d); n++) begin
            span_free[n] = LG_W'(TOTAL_LOG2 - d + 1);
         end
      end
      span_free[0] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: illegal sizes, the whole area, no space, frees of
      // offsets that hold nothing or sit inside a block, and a full merge
      // back to the root.
      queue_request(CMD_ALLOC, 0, 16'hFFFF, 1'b0);
      queue_request(CMD_ALLOC, AREA_SIZE + 1, 0, 1'b0);
      queue_request(CMD_ALLOC, (1 << SIZE_W) - 1, 0, 1'b0);
      queue_request(CMD_ALLOC, AREA_SIZE, 0, 1'b0);
      queue_request(CMD_ALLOC, 1, 0, 1'b0);
      queue_request(CMD_FREE, (1 << SIZE_W) - 1, 16'hFFFF, 1'b0);
      queue_request(CMD_FREE, 0, 0, 1'b0);
      queue_request(CMD_FREE, 0, 0, 1'b0);
      queue_request(CMD_ALLOC, 1, 0, 1'b0);
      queue_request(CMD_ALLOC, 16, 0, 1'b0);
      queue_request(CMD_ALLOC, 17, 0, 1'b0);
      queue_request(CMD_FREE, 0, 48, 1'b0);
      queue_request(CMD_ALLOC, AREA_SIZE / 2, 0, 1'b0);
      queue_request(CMD_ALLOC, AREA_SIZE / 2 + 1, 0, 1'b0);
      queue_request(CMD_FREE, 0, 16, 1'b0);
      queue_request(CMD_FREE, 0, 0, 1'b0);
      queue_request(CMD_FREE, 0, 32, 1'b0);
      queue_request(CMD_FREE, 0, AREA_SIZE / 2, 1'b0);
      // The sender waits here until every earlier response has come back.
      queue_request(CMD_ALLOC, AREA_SIZE - 1, 0, 1'b1);
      queue_request(CMD_FREE, (1 << SIZE_W) - 1, 0, 1'b0);
      made = backlog.size();

      // Random requests. Mostly well-formed: frees name blocks that were
      // granted. The alloc share drifts so the area fills and drains again.
      alloc_pct = 60;
      while (made < REQUEST_TOTAL) begin
         @(negedge clock);
         if (backlog.size() < 2) begin
            if (made % 64 == 0) alloc_pct = $urandom_range(25, 85);
            drain = ($urandom_range(0, 149) == 0);
            if ($urandom_range(0, 99) < alloc_pct) begin
               queue_request(CMD_ALLOC, pick_size(), $urandom_range(0, 16'hFFFF), drain);
            end else begin
               idx = $urandom_range(0, 19);
               if (held_blocks.size() > 0 && idx < 17) begin
                  off = $urandom_range(0, held_blocks.size() - 1);
                  if (idx == 0) begin
                     // Points inside a live block rather than at its start.
                     off = held_blocks[off] + $urandom_range(1, 15);
                  end else begin
                     idx = off;
                     off = held_blocks[idx];
                     held_blocks.delete(idx);
                  end
               end else begin
                  off = $urandom_range(0, 16'hFFFF);
               end
               queue_request(CMD_FREE, $urandom_range(0, (1 << SIZE_W) - 1), off, drain);
            end
            made++;
         end
      end

      // Wait until the last request is taken and answered, then let the
      // block settle before checking for missing responses.
      while (backlog.size() != 0 || start || in_flight != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_replies.size() != 0) begin
         flag_error($sformatf("%0d responses never arrived", expected_replies.size()));
      end

      $display("covered %0d requests, %0d responses: %0d succeeded, %0d bad size,",
               sent_count, reply_count, code_count[ERR_NONE], code_count[ERR_BAD_SIZE]);
      $display("%0d out of space, %0d frees of unallocated offsets; %0d mismatches",
               code_count[ERR_NO_SPACE], code_count[ERR_NOT_ALLOC], error_count);
      if (error_count == 0) begin
         $display("buddy_block_allocator_core regression: pass");
      end else begin
         $display("buddy_block_allocator_core regression: fail");
      end
      $finish;
   end

endmodule
